### design/rrts_pkg.sv
// rrts_pkg: types, sizes and controller states shared by the scheduler files.
// No dependencies; every other file of the block refers to it by scoped name.

package rrts_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned ID_W        = 8;
  localparam int unsigned BURST_W     = 16;
  localparam int unsigned QUANTUM_W   = 16;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(4);

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    process_id;
    logic [BURST_W-1:0] burst_length;
  } rrts_in_t;

  typedef struct packed {
    logic            is_tick;
    logic            busy_res;
    logic [ID_W-1:0] running_id;
    logic            finished;
    logic            rotated;
    logic            dropped;
  } rrts_out_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
  } rrts_entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } rrts_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } rrts_state_e;

endpackage

### design/round_robin_tick_scheduler.sv
// round_robin_tick_scheduler: top level of the tick-driven round-robin scheduler.
// Instantiates rrts_ctrl and rrts_datapath; types come from rrts_pkg.
//
// Usage:
// - input channel (in_valid_i/in_ready_o/in_data_i): each transfer is either a
//   process arrival (kind 0, queued unless its burst is zero or the queue is full)
//   or one scheduler tick (kind 1, runs the head process for one tick)
// - output channel (out_valid_o/out_ready_i/out_data_o): exactly one result
//   per input transfer, in input order
// - config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes the time
//   quantum, always ready; write it only while no item is in flight
// - an item is handled in order: the registered read of the queue head entry
//   from the queue memory, then the update, write-back and result load; no new
//   item is accepted until the previous one has been committed
// - the result is loaded into the output register once that register is free
// - reset empties the queue, clears the slice counter and sets the quantum
//   to 4; no clearing pass is needed
// - a stalled receiver holds the result in the output register; one more
//   item is accepted and then waits until the result slot frees up

module round_robin_tick_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rrts_pkg::rrts_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rrts_pkg::rrts_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_data_i
);

  rrts_pkg::rrts_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rrts_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

### design/rrts_ctrl.sv
// rrts_ctrl: handshake controller of the scheduler, sequences capture and commit.
// Depends on rrts_pkg for the state enum and the command struct.

module rrts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrts_pkg::rrts_cmd_t cmd_o
);

  rrts_pkg::rrts_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rrts_pkg::S_EXEC;
      end
      rrts_pkg::S_EXEC: begin
        if (out_free) state_d = rrts_pkg::S_IDLE;
      end
      default: state_d = rrts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      rrts_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      rrts_pkg::S_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/rrts_datapath.sv
// rrts_datapath: ready queue memory, head/count/slice registers and result register.
// Depends on rrts_pkg; driven by the command struct from rrts_ctrl.

module rrts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrts_pkg::rrts_cmd_t           cmd_i,
  input  rrts_pkg::rrts_in_t            in_data_i,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_data_i,
  output rrts_pkg::rrts_out_t           out_data_o
);

  localparam int unsigned IDX_W = rrts_pkg::IDX_W;
  localparam int unsigned CNT_W = rrts_pkg::CNT_W;
  localparam int unsigned SUM_W = rrts_pkg::SUM_W;
  localparam int unsigned QW    = rrts_pkg::QUANTUM_W;

  rrts_pkg::rrts_entry_t queue_mem_q [rrts_pkg::QUEUE_DEPTH];
  rrts_pkg::rrts_entry_t rd_q;
  rrts_pkg::rrts_in_t    item_q;
  rrts_pkg::rrts_out_t   out_q, out_d;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [QW-1:0]    slice_q, slice_d;
  logic [QW-1:0]    quantum_q;

  logic [SUM_W-1:0]           tail_sum;
  logic [IDX_W-1:0]           tail_idx;
  logic [IDX_W-1:0]           head_inc;
  logic [QW-1:0]              slice_inc;
  logic [rrts_pkg::BURST_W-1:0] rem_dec;
  logic                       queue_full;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  rrts_pkg::rrts_entry_t      mem_wdata;

  assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail_idx  = (tail_sum >= SUM_W'(rrts_pkg::QUEUE_DEPTH))
                     ? IDX_W'(tail_sum - SUM_W'(rrts_pkg::QUEUE_DEPTH))
                     : IDX_W'(tail_sum);
  assign head_inc  = (head_q == IDX_W'(rrts_pkg::QUEUE_DEPTH - 1))
                     ? '0 : head_q + IDX_W'(1);
  assign slice_inc = slice_q + QW'(1);
  assign rem_dec   = rd_q.remaining - rrts_pkg::BURST_W'(1);
  assign queue_full = (count_q == CNT_W'(rrts_pkg::QUEUE_DEPTH));

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    slice_d   = slice_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = '{id: rd_q.id, remaining: rem_dec};
    out_d     = '0;
    out_d.is_tick = item_q.kind;
    if (item_q.kind == rrts_pkg::KIND_ARRIVAL) begin
      if (item_q.burst_length == '0 || queue_full) begin
        out_d.dropped = 1'b1;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = tail_idx;
        mem_wdata = '{id: item_q.process_id, remaining: item_q.burst_length};
        count_d   = count_q + CNT_W'(1);
      end
    end else if (count_q != '0) begin
      out_d.busy_res   = 1'b1;
      out_d.running_id = rd_q.id;
      if (rem_dec == '0) begin
        out_d.finished = 1'b1;
        head_d  = head_inc;
        count_d = count_q - CNT_W'(1);
        slice_d = '0;
      end else if (quantum_q != '0 && slice_inc >= quantum_q) begin
        out_d.rotated = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = tail_idx;
        head_d    = head_inc;
        slice_d   = '0;
      end else begin
        mem_we  = 1'b1;
        slice_d = slice_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= queue_mem_q[head_q];
    if (cmd_i.commit && mem_we) queue_mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    if (cmd_i.commit) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      slice_q   <= '0;
      quantum_q <= rrts_pkg::QUANTUM_RESET;
    end else begin
      if (cmd_i.commit) begin
        head_q  <= head_d;
        count_q <= count_d;
        slice_q <= slice_d;
      end
      if (cfg_we_i) quantum_q <= cfg_data_i;
    end
  end

  assign out_data_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(rrts_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < IDX_W'(rrts_pkg::QUEUE_DEPTH - 1) || head_q == IDX_W'(rrts_pkg::QUEUE_DEPTH - 1))
    else $error("head index out of range");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && item_q.kind == rrts_pkg::KIND_ARRIVAL && !out_d.dropped
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted arrival did not grow the queue");

  a_finish_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && out_d.finished |=> count_q == $past(count_q) - CNT_W'(1) && slice_q == '0)
    else $error("finished process not removed");

  a_fin_rot_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_d.finished && out_d.rotated))
    else $error("finish and rotate on one tick");

endmodule

### tb/round_robin_tick_scheduler_checker.sv
// round_robin_tick_scheduler_checker: watches the input, config and result channels,
// predicts each result of the round-robin scheduler and compares it field by field.
// Depends on rrts_pkg for the payload types and sizes.

module round_robin_tick_scheduler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  rrts_pkg::rrts_in_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  rrts_pkg::rrts_out_t            out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             result_count_o,
  output int                             rotation_count_o,
  output int                             finish_count_o,
  output int                             drop_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [rrts_pkg::ID_W-1:0]      ready_ids  [rrts_pkg::QUEUE_DEPTH];
  logic [rrts_pkg::BURST_W-1:0]   ready_left [rrts_pkg::QUEUE_DEPTH];
  int unsigned                    ready_head;
  int unsigned                    ready_count;
  logic [rrts_pkg::QUANTUM_W-1:0] slice_ticks;
  logic [rrts_pkg::QUANTUM_W-1:0] quantum;

  rrts_pkg::rrts_out_t expected_results[$];
  int fails;
  int pending;
  int results;
  int rotations;
  int finishes;
  int drops;

  assign fail_count_o     = fails;
  assign pending_o        = pending;
  assign result_count_o   = results;
  assign rotation_count_o = rotations;
  assign finish_count_o   = finishes;
  assign drop_count_o     = drops;

  function automatic rrts_pkg::rrts_out_t schedule_item(input rrts_pkg::rrts_in_t item);
    rrts_pkg::rrts_out_t          res;
    int unsigned                  slot;
    int unsigned                  head;
    logic [rrts_pkg::BURST_W-1:0] left;
    res = '0;
    res.is_tick = item.kind;
    if (item.kind == rrts_pkg::KIND_ARRIVAL) begin
      if (item.burst_length == '0 || ready_count >= rrts_pkg::QUEUE_DEPTH) begin
        res.dropped = 1'b1;
      end else begin
        slot = (ready_head + ready_count) % rrts_pkg::QUEUE_DEPTH;
        ready_ids[slot]  = item.process_id;
        ready_left[slot] = item.burst_length;
        ready_count++;
      end
    end else if (ready_count != 0) begin
      head = ready_head;
      left = ready_left[head] - 1'b1;
      ready_left[head] = left;
      res.busy_res   = 1'b1;
      res.running_id = ready_ids[head];
      slice_ticks    = slice_ticks + 1'b1;
      if (left == '0) begin
        res.finished = 1'b1;
        ready_head   = (head + 1) % rrts_pkg::QUEUE_DEPTH;
        ready_count--;
        slice_ticks  = '0;
      end else if (quantum != '0 && slice_ticks >= quantum) begin
        // head moves to the tail; with one entry it is copied to the next slot, which becomes the head
        slot = (head + ready_count) % rrts_pkg::QUEUE_DEPTH;
        ready_ids[slot]  = ready_ids[head];
        ready_left[slot] = left;
        ready_head   = (head + 1) % rrts_pkg::QUEUE_DEPTH;
        slice_ticks  = '0;
        res.rotated  = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rrts_pkg::rrts_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < rrts_pkg::QUEUE_DEPTH; i++) begin
        ready_ids[i]  = '0;
        ready_left[i] = '0;
      end
      ready_head  = 0;
      ready_count = 0;
      slice_ticks = '0;
      quantum     = rrts_pkg::QUANTUM_RESET;
      expected_results.delete();
      fails     = 0;
      pending   = 0;
      results   = 0;
      rotations = 0;
      finishes  = 0;
      drops     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result %0h with nothing expected", $time, out_data_i);
          fails++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_data_i.is_tick !== want.is_tick)
            report("is_tick", want.is_tick, out_data_i.is_tick);
          if (out_data_i.busy_res !== want.busy_res)
            report("busy_res", want.busy_res, out_data_i.busy_res);
          if (out_data_i.running_id !== want.running_id)
            report("running_id", want.running_id, out_data_i.running_id);
          if (out_data_i.finished !== want.finished)
            report("finished", want.finished, out_data_i.finished);
          if (out_data_i.rotated !== want.rotated)
            report("rotated", want.rotated, out_data_i.rotated);
          if (out_data_i.dropped !== want.dropped)
            report("dropped", want.dropped, out_data_i.dropped);
          rotations += want.rotated;
          finishes  += want.finished;
          drops     += want.dropped;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        quantum = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.insert(expected_results.size(), schedule_item(in_data_i));
      end
      pending = expected_results.size();
    end
  end

endmodule

### tb/round_robin_tick_scheduler_tb.sv
// round_robin_tick_scheduler_tb: clock, reset and stimulus for the round-robin scheduler,
// with random idling on both channels; checking is done by round_robin_tick_scheduler_checker.
// Depends on rrts_pkg, round_robin_tick_scheduler and the checker module.

module round_robin_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 80;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  rrts_pkg::rrts_in_t             in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  rrts_pkg::rrts_out_t            out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [rrts_pkg::QUANTUM_W-1:0] cfg_data_i  = '0;

  int fail_count;
  int pending;
  int result_count;
  int rotations;
  int finishes;
  int drops;

  bit calm          = 1'b0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int sent          = 0;

  always #HALF_PERIOD clk_i = ~clk_i;

  round_robin_tick_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  round_robin_tick_scheduler_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .result_count_o   (result_count),
    .rotation_count_o (rotations),
    .finish_count_o   (finishes),
    .drop_count_o     (drops)
  );

  // result side: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("round_robin_tick_scheduler regression: fail");
      $finish;
    end
  end

  task automatic offer(input rrts_pkg::rrts_in_t item);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic arrive(input logic [rrts_pkg::ID_W-1:0] pid,
                        input logic [rrts_pkg::BURST_W-1:0] burst);
    rrts_pkg::rrts_in_t item;
    item.kind         = rrts_pkg::KIND_ARRIVAL;
    item.process_id   = pid;
    item.burst_length = burst;
    offer(item);
  endtask

  task automatic run_ticks(input int n);
    rrts_pkg::rrts_in_t item;
    repeat (n) begin
      item.kind         = rrts_pkg::KIND_TICK;
      item.process_id   = rrts_pkg::ID_W'($urandom);
      item.burst_length = rrts_pkg::BURST_W'($urandom);
      offer(item);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_quantum(input logic [rrts_pkg::QUANTUM_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic rrts_pkg::rrts_in_t random_item(input int arrive_pct);
    rrts_pkg::rrts_in_t item;
    int                 pick;
    item.process_id   = rrts_pkg::ID_W'($urandom);
    item.burst_length = rrts_pkg::BURST_W'($urandom);
    item.kind         = rrts_pkg::KIND_TICK;
    if ($urandom_range(99) < arrive_pct) begin
      item.kind = rrts_pkg::KIND_ARRIVAL;
      pick = $urandom_range(99);
      if (pick < 5) begin
        item.burst_length = '0;
      end else if (pick >= 8) begin
        item.burst_length = rrts_pkg::BURST_W'($urandom_range(12, 1));
      end
    end
    return item;
  endfunction

  function automatic logic [rrts_pkg::QUANTUM_W-1:0] phase_quantum(input int phase);
    case (phase)
      0:       return rrts_pkg::QUANTUM_W'(1);
      1:       return rrts_pkg::QUANTUM_W'(5);
      2:       return '0;
      3:       return '1;
      4:       return rrts_pkg::QUANTUM_W'($urandom_range(8, 1));
      default: return rrts_pkg::QUANTUM_W'(2);
    endcase
  endfunction

  function automatic int phase_arrivals(input int phase);
    case (phase)
      0:       return 45;
      1:       return 65;
      2:       return 35;
      3:       return 50;
      4:       return 40;
      default: return 55;
    endcase
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle tick, zero burst, extreme ids and bursts, rotate and finish on one tick
    set_quantum(rrts_pkg::QUANTUM_W'(2));
    run_ticks(1);
    arrive(8'hA5, '0);
    arrive(8'hFF, 16'hFFFF);
    arrive(8'h00, 16'd2);
    run_ticks(6);
    // slice grows under quantum 0, then a lower quantum rotates at once
    set_quantum('0);
    run_ticks(5);
    set_quantum(rrts_pkg::QUANTUM_W'(3));
    run_ticks(1);
    // fill the queue, last arrival is dropped
    for (int i = 1; i <= 16; i++) begin
      arrive(rrts_pkg::ID_W'(i * 15), rrts_pkg::BURST_W'(i));
    end

    for (int p = 0; p < PHASES; p++) begin
      set_quantum(phase_quantum(p));
      calm = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) begin
          hold_requests++;
        end
        if (p == 4 && n == 40) begin
          drain();
        end
        offer(random_item(phase_arrivals(p)));
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(negedge clk_i);
    $display("%0d items over seven quantum settings (0 and 65535 among them), %0d results checked",
             sent, result_count);
    $display("%0d finishes, %0d rotations, %0d dropped arrivals, %0d mismatches",
             finishes, rotations, drops, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("round_robin_tick_scheduler regression: pass");
    end else begin
      $display("round_robin_tick_scheduler regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/rrts_pkg.sv
design/rrts_ctrl.sv
design/rrts_datapath.sv
design/round_robin_tick_scheduler.sv
tb/round_robin_tick_scheduler_checker.sv
tb/round_robin_tick_scheduler_tb.sv
